[rtl/core/alwu_pkg.sv]
package alwu_pkg;

    localparam int DEF_FEATURE_COUNT = 4096;
    localparam int ENTRY_W           = 96;

    localparam logic [15:0] RST_LEARNING_RATE     = 16'd66;
    localparam logic [15:0] RST_FIRST_DECAY       = 16'd58982;
    localparam logic [15:0] RST_SECOND_DECAY      = 16'd65470;
    localparam logic [15:0] RST_REGULARIZATION    = 16'd0;
    localparam logic [31:0] RST_FIRST_CORRECTION  = 32'd655360;
    localparam logic [31:0] RST_SECOND_CORRECTION = 32'd65601536;
    localparam logic [15:0] RST_EPSILON_TERM      = 16'd17;

    typedef enum logic [2:0] {
        CFG_LEARNING_RATE     = 3'd0,
        CFG_FIRST_DECAY       = 3'd1,
        CFG_SECOND_DECAY      = 3'd2,
        CFG_REGULARIZATION    = 3'd3,
        CFG_FIRST_CORRECTION  = 3'd4,
        CFG_SECOND_CORRECTION = 3'd5,
        CFG_EPSILON_TERM      = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_GSQ,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_V1,
        ST_V2,
        ST_MT,
        ST_VT,
        ST_SQ_INIT,
        ST_SQ,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } t_state;

    // control from the sequencer to the state memory
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // saturate a wide signed value to signed 32 bits, flag in the top bit
    function automatic logic [32:0] sat_s32(input logic signed [66:0] v);
        logic [32:0] r;
        if (v > 67'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -67'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // saturate a non-negative wide value to unsigned 32 bits
    function automatic logic [32:0] sat_u32(input logic signed [66:0] v);
        logic [32:0] r;
        if (v > 67'sd4294967295) begin
            r = {1'b1, 32'hFFFF_FFFF};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[rtl/core/alwu_mem.sv]
module alwu_mem
    import alwu_pkg::*;
#(
    parameter int DEPTH = DEF_FEATURE_COUNT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mem_ctl           i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic [ENTRY_W-1:0] i_wdata,
    output logic [ENTRY_W-1:0] o_rdata,
    output logic               o_busy
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clr_busy;

    // zero sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

[rtl/core/adam_linear_weight_update.sv]
// channel | direction | handshake                  | payload
// input   | in        | i_valid / o_ready          | i_func, i_feature_index,
//         |           |                            | i_feature_value, i_partial_grad
// result  | out       | o_valid / i_ready          | o_new_weight, o_saturated
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an item goes through read and load, 10 products of the one shared 33x33 multiplier
// (8 for bias) plus a sum step for g, an init step and the bit-pair square root,
// an init step and the bit-serial divider, and write-back, one item at a time; o_ready
// is high only while the sequencer is idle, so a new item is taken only once the last
// one is through write-back; a result that is not taken holds write-back
// a finished result waits in the output register and the next item is taken meanwhile
// after reset the state memory is zeroed one entry per cycle, all FEATURE_COUNT entries,
// with o_ready low; config writes are taken at all times
module adam_linear_weight_update
    import alwu_pkg::*;
#(
    parameter int FEATURE_COUNT = DEF_FEATURE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [11:0] i_feature_index,
    input  logic [31:0] i_feature_value,
    input  logic [31:0] i_partial_grad,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_new_weight,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(FEATURE_COUNT);

    // configuration registers
    logic [15:0] r_lr, r_b1, r_b2, r_lambda, r_eps;
    logic [31:0] r_fc, r_sc;

    // sequencer
    t_state r_state, n_state;

    // item fields
    logic          r_func;
    logic          r_skip;
    logic [AW-1:0] r_addr;
    logic [31:0]   r_x, r_pg;

    // bias state
    logic [31:0] r_bias_w, r_bias_m, r_bias_v;

    // working values
    logic [31:0] r_w, r_m, r_v;
    logic [31:0] r_g, r_gsq, r_mn, r_vn, r_mt, r_vt;
    logic        r_sat;

    // shared multiplier and accumulator
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_prod, r_prod;
    logic signed [66:0] r_acc, acc_sum, prod_ext;

    // square root
    logic [40:0] r_op, r_bit;
    logic [41:0] r_res, sq_try;

    // divider
    logic [47:0] r_num, r_quo;
    logic [20:0] r_den, root_val;
    logic [20:0] r_rem;
    logic [21:0] rem_sh;
    logic [5:0]  r_cnt;
    logic        r_neg;

    // output register
    logic        r_out_valid, r_out_sat;
    logic [31:0] r_out_w;

    // memory interface
    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic               mem_busy;

    logic        in_fire, out_free, in_range;
    logic [32:0] g_sat, gsq_sat, mn_sat, vn_sat, mt_sat, vt_sat, w_sat;
    logic signed [66:0] step_val;

    alwu_mem #(
        .DEPTH (FEATURE_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= RST_LEARNING_RATE;
            r_b1     <= RST_FIRST_DECAY;
            r_b2     <= RST_SECOND_DECAY;
            r_lambda <= RST_REGULARIZATION;
            r_fc     <= RST_FIRST_CORRECTION;
            r_sc     <= RST_SECOND_CORRECTION;
            r_eps    <= RST_EPSILON_TERM;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEARNING_RATE:     r_lr     <= i_cfg_data[15:0];
                CFG_FIRST_DECAY:       r_b1     <= i_cfg_data[15:0];
                CFG_SECOND_DECAY:      r_b2     <= i_cfg_data[15:0];
                CFG_REGULARIZATION:    r_lambda <= i_cfg_data[15:0];
                CFG_FIRST_CORRECTION:  r_fc     <= i_cfg_data;
                CFG_SECOND_CORRECTION: r_sc     <= i_cfg_data;
                CFG_EPSILON_TERM:      r_eps    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign in_range = {20'd0, i_feature_index} < 32'(FEATURE_COUNT);

    // multiplier operand select, one product per step
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_G1: begin
                m_a = {17'd0, r_lambda};
                m_b = {r_w[31], r_w};
            end
            ST_G2: begin
                m_a = {r_pg[31], r_pg};
                m_b = {r_x[31], r_x};
            end
            ST_GSQ: begin
                m_a = {r_g[31], r_g};
                m_b = {r_g[31], r_g};
            end
            ST_M1: begin
                m_a = {17'd0, r_b1};
                m_b = {r_m[31], r_m};
            end
            ST_M2: begin
                m_a = {16'd0, 17'h10000 - {1'b0, r_b1}};
                m_b = {r_g[31], r_g};
            end
            ST_M3: begin
                m_a = {17'd0, r_b2};
                m_b = {1'b0, r_v};
            end
            ST_V1: begin
                m_a = {16'd0, 17'h10000 - {1'b0, r_b2}};
                m_b = {1'b0, r_gsq};
            end
            ST_V2: begin
                m_a = {r_mn[31], r_mn};
                m_b = {1'b0, r_fc};
            end
            ST_MT: begin
                m_a = {1'b0, r_vn};
                m_b = {1'b0, r_sc};
            end
            ST_VT: begin
                m_a = {17'd0, r_lr};
                m_b = {r_mt[31], r_mt};
            end
            default: ;
        endcase
    end

    assign m_prod   = m_a * m_b;
    assign prod_ext = {r_prod[65], r_prod};
    assign acc_sum  = r_acc + prod_ext;

    // rounding and clamping of each stage result
    assign g_sat   = sat_s32((acc_sum + 67'sd32768) >>> 16);
    assign gsq_sat = sat_u32((prod_ext + 67'sd128) >>> 8);
    assign mn_sat  = sat_s32((acc_sum + 67'sd32768) >>> 16);
    assign vn_sat  = sat_u32((acc_sum + 67'sd32768) >>> 16);
    assign mt_sat  = sat_s32((prod_ext + 67'sd32768) >>> 16);
    assign vt_sat  = sat_u32((prod_ext + 67'sd32768) >>> 16);

    assign sq_try   = r_res + {1'b0, r_bit};
    assign root_val = (r_res[20:0] == 21'd0) ? 21'd1 : r_res[20:0];
    assign rem_sh   = {r_rem, r_quo[47]};

    // signed step and new weight
    assign step_val = r_neg ? -$signed({19'd0, r_quo}) : $signed({19'd0, r_quo});
    assign w_sat    = sat_s32($signed({{35{r_w[31]}}, r_w}) - step_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        mem_ctl.rd  = 1'b0;
        mem_ctl.wr  = 1'b0;
        mem_addr    = r_addr;
        case (r_state)
            ST_IDLE: begin
                o_ready = !mem_busy;
                if (in_fire) begin
                    mem_addr   = AW'(i_feature_index);
                    mem_ctl.rd = i_func && in_range;
                    if (i_func && !in_range) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:       n_state = ST_LOAD;
            ST_LOAD:     n_state = r_func ? ST_G1 : ST_GSQ;
            ST_G1:       n_state = ST_G2;
            ST_G2:       n_state = ST_G3;
            ST_G3:       n_state = ST_GSQ;
            ST_GSQ:      n_state = ST_M1;
            ST_M1:       n_state = ST_M2;
            ST_M2:       n_state = ST_M3;
            ST_M3:       n_state = ST_V1;
            ST_V1:       n_state = ST_V2;
            ST_V2:       n_state = ST_MT;
            ST_MT:       n_state = ST_VT;
            ST_VT:       n_state = ST_SQ_INIT;
            ST_SQ_INIT:  n_state = ST_SQ;
            ST_SQ: begin
                if (r_bit[0]) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    mem_ctl.wr = r_func && !r_skip;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign mem_wdata = {w_sat[31:0], r_mn, r_vn};

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_prod;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_func <= i_func;
                    r_skip <= i_func && !in_range;
                    r_addr <= AW'(i_feature_index);
                    r_x    <= i_feature_value;
                    r_pg   <= i_partial_grad;
                    r_sat  <= 1'b0;
                end
            end
            ST_LOAD: begin
                if (r_func) begin
                    r_w <= mem_rdata[95:64];
                    r_m <= mem_rdata[63:32];
                    r_v <= mem_rdata[31:0];
                end else begin
                    r_w <= r_bias_w;
                    r_m <= r_bias_m;
                    r_v <= r_bias_v;
                    r_g <= r_pg;
                end
            end
            ST_G2: r_acc <= prod_ext;
            ST_G3: begin
                r_g   <= g_sat[31:0];
                r_sat <= r_sat | g_sat[32];
            end
            ST_M1: begin
                r_gsq <= gsq_sat[31:0];
                r_sat <= r_sat | gsq_sat[32];
            end
            ST_M2: r_acc <= prod_ext;
            ST_M3: begin
                r_mn  <= mn_sat[31:0];
                r_sat <= r_sat | mn_sat[32];
            end
            ST_V1: r_acc <= prod_ext;
            ST_V2: begin
                r_vn  <= vn_sat[31:0];
                r_sat <= r_sat | vn_sat[32];
            end
            ST_MT: begin
                r_mt  <= mt_sat[31:0];
                r_sat <= r_sat | mt_sat[32];
            end
            ST_VT: begin
                r_vt  <= vt_sat[31:0];
                r_sat <= r_sat | vt_sat[32];
            end
            ST_SQ_INIT: begin
                // lr * mt is at most 48 bits signed
                r_num <= r_prod[47:0];
                r_op  <= {({1'b0, r_vt} + {17'd0, r_eps}), 8'd0};
                r_bit <= {1'b1, 40'd0};
                r_res <= '0;
            end
            ST_SQ: begin
                if ({1'b0, r_op} >= sq_try) begin
                    r_op  <= r_op - sq_try[40:0];
                    r_res <= (r_res >> 1) + {1'b0, r_bit};
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIV_INIT: begin
                r_neg <= r_num[47];
                r_quo <= (r_num[47] ? -r_num : r_num) + 48'(root_val >> 1);
                r_den <= root_val;
                r_rem <= '0;
                r_cnt <= 6'd47;
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= 21'(rem_sh - {1'b0, r_den});
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[20:0];
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    // bias entry and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_w    <= '0;
            r_bias_m    <= '0;
            r_bias_v    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (!r_func) begin
                    r_bias_w <= w_sat[31:0];
                    r_bias_m <= r_mn;
                    r_bias_v <= r_vn;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_w   <= r_skip ? 32'd0 : w_sat[31:0];
            r_out_sat <= r_skip ? 1'b0 : (r_sat | w_sat[32]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_new_weight = r_out_w;
    assign o_saturated  = r_out_sat;

    // writes to the state memory only at the end of an in-range feature item
    a_wr_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr |-> (r_state == ST_DONE && r_func && !r_skip))
        else $error("state memory written outside write-back");

    // no item is taken while the zero sweep runs
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> !o_ready)
        else $error("item accepted during memory clear");

    // the root bit walks as a single bit
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> $onehot(r_bit))
        else $error("square root bit lost");

    // a completed item always shows up on the result port
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (o_valid && r_state == ST_IDLE))
        else $error("result not presented");

    // a read is always followed by the load of its data
    a_read_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.rd |=> (r_state == ST_RD) ##1 (r_state == ST_LOAD))
        else $error("read not followed by load");

endmodule

[test/tb_adam_linear_weight_update.sv]
`timescale 1ns / 1ps

module tb_adam_linear_weight_update;
    import alwu_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        bit        func;
        bit [11:0] idx;
        bit [31:0] x;
        bit [31:0] pg;
    } t_update;

    typedef struct {
        logic [31:0] weight;
        logic        sat;
    } t_weight_res;

    typedef struct {
        t_cfg_idx    idx;
        logic [31:0] data;
    } t_reg_write;

    // clock and reset
    logic i_clk;
    logic i_rst_n;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // block ports
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [11:0] i_feature_index;
    logic [31:0] i_feature_value;
    logic [31:0] i_partial_grad;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_new_weight;
    logic        o_saturated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    adam_linear_weight_update i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_feature_index (i_feature_index),
        .i_feature_value (i_feature_value),
        .i_partial_grad  (i_partial_grad),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_new_weight    (o_new_weight),
        .o_saturated     (o_saturated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // queues between the stimulus process and the clocked driver and checker
    t_update     pending_updates[$];
    t_reg_write  pending_writes[$];
    t_weight_res expected_weights[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_trigger;
    int          errors;

    // predictor state, a mirror of the weight and moment memories
    t_wide weight_mem[4096];
    t_wide moment1_mem[4096];
    t_wide moment2_mem[4096];
    t_wide bias_w, bias_m, bias_v;
    t_wide lr, beta1, beta2, lambda, corr1, corr2, eps;

    function automatic t_wide rnd_shift(input t_wide v, input int n);
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide clamp_signed(input t_wide v, inout bit sat);
        if (v > t_wide'(32'sh7FFF_FFFF)) begin
            sat = 1'b1;
            return t_wide'(32'sh7FFF_FFFF);
        end
        if (v < -t_wide'(64'sh8000_0000)) begin
            sat = 1'b1;
            return -t_wide'(64'sh8000_0000);
        end
        return v;
    endfunction

    function automatic t_wide clamp_unsigned(input t_wide v, inout bit sat);
        if (v > t_wide'(64'hFFFF_FFFF)) begin
            sat = 1'b1;
            return t_wide'(64'hFFFF_FFFF);
        end
        return v;
    endfunction

    // integer square root, one result bit per pass from the top
    function automatic t_wide int_sqrt(input t_wide op);
        t_wide r;
        t_wide t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (t_wide'(1) <<< b);
            if (t * t <= op) begin
                r = t;
            end
        end
        return r;
    endfunction

    // one Adam step on a weight and its two moments
    function automatic void adam_step(inout t_wide w, inout t_wide m, inout t_wide v,
                                      input t_wide g, inout bit sat);
        t_wide gsq, mn, vn, mt, vt, root, num, mag, stp;
        gsq  = clamp_unsigned((g * g + 128) >>> 8, sat);
        mn   = clamp_signed(rnd_shift(beta1 * m + (65536 - beta1) * g, 16), sat);
        vn   = clamp_unsigned((beta2 * v + (65536 - beta2) * gsq + 32768) >>> 16, sat);
        mt   = clamp_signed(rnd_shift(mn * corr1, 16), sat);
        vt   = clamp_unsigned((vn * corr2 + 32768) >>> 16, sat);
        root = int_sqrt((vt + eps) <<< 8);
        // zero root is taken as one
        if (root == 0) begin
            root = 1;
        end
        num = lr * mt;
        mag = (num < 0) ? -num : num;
        stp = (mag + root / 2) / root;
        if (num < 0) begin
            stp = -stp;
        end
        m = mn;
        v = vn;
        w = clamp_signed(w - stp, sat);
    endfunction

    function automatic t_weight_res predict_update(input t_update it);
        t_weight_res r;
        t_wide       g;
        bit          sat;
        sat = 1'b0;
        if (!it.func) begin
            // bias item: index and feature value play no part
            adam_step(bias_w, bias_m, bias_v, t_wide'($signed(it.pg)), sat);
            r.weight = bias_w[31:0];
        end else begin
            g = clamp_signed(rnd_shift(lambda * weight_mem[it.idx]
                    + t_wide'($signed(it.pg)) * t_wide'($signed(it.x)), 16), sat);
            adam_step(weight_mem[it.idx], moment1_mem[it.idx], moment2_mem[it.idx], g, sat);
            r.weight = weight_mem[it.idx][31:0];
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic void apply_write(input t_reg_write wr);
        case (wr.idx)
            CFG_LEARNING_RATE:     lr     = t_wide'(wr.data[15:0]);
            CFG_FIRST_DECAY:       beta1  = t_wide'(wr.data[15:0]);
            CFG_SECOND_DECAY:      beta2  = t_wide'(wr.data[15:0]);
            CFG_REGULARIZATION:    lambda = t_wide'(wr.data[15:0]);
            CFG_FIRST_CORRECTION:  corr1  = t_wide'(wr.data);
            CFG_SECOND_CORRECTION: corr2  = t_wide'(wr.data);
            CFG_EPSILON_TERM:      eps    = t_wide'(wr.data[15:0]);
            default: ;
        endcase
    endfunction

    // update driver: takes the next item off the pending queue
    always @(posedge i_clk) begin
        t_update nxt;
        bit      busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && o_ready) begin
                nxt.func = i_func;
                nxt.idx  = i_feature_index;
                nxt.x    = i_feature_value;
                nxt.pg   = i_partial_grad;
                expected_weights.push_back(predict_update(nxt));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_updates.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_updates.pop_front();
                    i_valid         <= 1'b1;
                    i_func          <= nxt.func;
                    i_feature_index <= nxt.idx;
                    i_feature_value <= nxt.x;
                    i_partial_grad  <= nxt.pg;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        t_reg_write wr;
        bit         busy;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            busy = i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                wr.idx  = t_cfg_idx'(i_cfg_index);
                wr.data = i_cfg_data;
                apply_write(wr);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_writes.size() > 0) begin
                    wr = pending_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= wr.idx;
                    i_cfg_data  <= wr.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result checker with random stalls and a long hold-off on request
    int unsigned hold_left;
    bit          hold_seen;

    always @(posedge i_clk) begin
        t_weight_res exp_r;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_weights.size() == 0) begin
                    $display("%0t: result with nothing expected: weight %h sat %b",
                             $time, o_new_weight, o_saturated);
                    errors++;
                end else begin
                    exp_r = expected_weights.pop_front();
                    if (o_new_weight !== exp_r.weight) begin
                        $display("%0t: new_weight expected %h actual %h",
                                 $time, exp_r.weight, o_new_weight);
                        errors++;
                    end
                    if (o_saturated !== exp_r.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_r.sat, o_saturated);
                        errors++;
                    end
                end
            end
            if (hold_trigger != hold_seen) begin
                hold_seen <= hold_trigger;
                hold_left <= 600;
                i_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // signed Q16.16 operand: half small, some full range, some corners
    function automatic bit [31:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50) begin
            return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        end else if (sel < 80) begin
            return $urandom;
        end else begin
            case ($urandom_range(4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
    endfunction

    function automatic t_update random_update();
        t_update it;
        it.func = ($urandom_range(99) >= 20);
        // a few hot entries so the moments build up, rest anywhere
        // entries 3000..3009 stay fresh for the zero root check
        if ($urandom_range(99) < 70) begin
            it.idx = 12'($urandom_range(15));
        end else begin
            do begin
                it.idx = 12'($urandom);
            end while (it.idx >= 3000 && it.idx <= 3009);
        end
        it.x  = pick_operand();
        it.pg = pick_operand();
        return it;
    endfunction

    function automatic t_update mk(input bit f, input bit [11:0] i,
                                   input bit [31:0] x, input bit [31:0] pg);
        t_update it;
        it.func = f;
        it.idx  = i;
        it.x    = x;
        it.pg   = pg;
        return it;
    endfunction

    task automatic drain();
        wait (pending_updates.size() == 0 && !i_valid && expected_weights.size() == 0);
        // let any tail of work settle before touching registers
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] v_lr, input logic [31:0] v_b1,
                              input logic [31:0] v_b2, input logic [31:0] v_lam,
                              input logic [31:0] v_c1, input logic [31:0] v_c2,
                              input logic [31:0] v_eps);
        pending_writes.push_back('{CFG_LEARNING_RATE, v_lr});
        pending_writes.push_back('{CFG_FIRST_DECAY, v_b1});
        pending_writes.push_back('{CFG_SECOND_DECAY, v_b2});
        pending_writes.push_back('{CFG_REGULARIZATION, v_lam});
        pending_writes.push_back('{CFG_FIRST_CORRECTION, v_c1});
        pending_writes.push_back('{CFG_SECOND_CORRECTION, v_c2});
        pending_writes.push_back('{CFG_EPSILON_TERM, v_eps});
        wait (pending_writes.size() == 0 && !i_cfg_valid);
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_updates.push_back(random_update());
    endtask

    // stimulus
    initial begin
        errors          = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_trigger    = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_func          = 1'b0;
        i_feature_index = '0;
        i_feature_value = '0;
        i_partial_grad  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        foreach (weight_mem[k]) begin
            weight_mem[k]  = 0;
            moment1_mem[k] = 0;
            moment2_mem[k] = 0;
        end
        bias_w = 0;
        bias_m = 0;
        bias_v = 0;
        lr     = t_wide'(RST_LEARNING_RATE);
        beta1  = t_wide'(RST_FIRST_DECAY);
        beta2  = t_wide'(RST_SECOND_DECAY);
        lambda = t_wide'(RST_REGULARIZATION);
        corr1  = t_wide'(RST_FIRST_CORRECTION);
        corr2  = t_wide'(RST_SECOND_CORRECTION);
        eps    = t_wide'(RST_EPSILON_TERM);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at reset settings: bias corners, feature corners
        pending_updates.push_back(mk(1'b0, 12'd0, 32'h0, 32'h7FFF_FFFF));
        pending_updates.push_back(mk(1'b0, 12'hABC, 32'h1234_5678, 32'h8000_0000));
        pending_updates.push_back(mk(1'b0, 12'hFFF, 32'hFFFF_FFFF, 32'h0));
        pending_updates.push_back(mk(1'b0, 12'd5, 32'h8000_0000, 32'h0000_0001));
        pending_updates.push_back(mk(1'b1, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_updates.push_back(mk(1'b1, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_updates.push_back(mk(1'b1, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_updates.push_back(mk(1'b1, 12'hFFF, 32'h8000_0000, 32'h8000_0000));
        pending_updates.push_back(mk(1'b1, 12'd1, 32'hFFFF_FFFF, 32'h0000_0001));
        pending_updates.push_back(mk(1'b1, 12'd2, 32'h0001_0000, 32'hFFFF_0000));
        pending_updates.push_back(mk(1'b1, 12'd2, 32'h0001_0000, 32'h0001_0000));
        pending_updates.push_back(mk(1'b1, 12'd3, 32'h0, 32'h0));
        pending_updates.push_back(mk(1'b1, 12'd0, 32'h0000_8000, 32'hFFFF_8000));
        pending_updates.push_back(mk(1'b0, 12'd0, 32'h0, 32'hFFFF_FFFF));
        drain();

        // typical settings, sender idling
        write_regs(32'd1000, 32'd58982, 32'd65470, 32'd655,
                   32'd196608, 32'd3276800, 32'd17);
        send_idle_pct = 46;
        queue_random(300);
        drain();

        // first set of extremes, receiver stalling
        write_regs(32'd65535, 32'd0, 32'd0, 32'd65535,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        queue_random(300);
        drain();

        // second set of extremes, both sides idling; fresh entry with no gradient
        // gives a zero root
        write_regs(32'd0, 32'd65535, 32'd65535, 32'd0,
                   32'd65536, 32'd65536, 32'd0);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        pending_updates.push_back(mk(1'b1, 12'd3000, 32'h7FFF_FFFF, 32'h0));
        queue_random(300);
        drain();

        // random settings, no idling, long receiver hold so the block backs up
        write_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), 32'h0001_0000 + $urandom_range(32'h00FF_FFFF),
                   32'h0001_0000 + $urandom_range(32'h0FFF_FFFF), 32'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pending_updates.push_back(mk(1'b1, 12'd3001, 32'h1, 32'h0));
        queue_random(300);
        hold_trigger = ~hold_trigger;
        drain();

        if (errors == 0 && expected_weights.size() == 0) begin
            $display("tb_adam_linear_weight_update: PASS");
        end else begin
            $display("tb_adam_linear_weight_update: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb_adam_linear_weight_update: FAIL");
        $finish;
    end

endmodule
